### rtl/tkst_pkg.sv
// Package: shared widths, command codes and request/result types for the score table.
`timescale 1ns / 1ps
package tkst_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int TAG_BITS_DEF      = 16;
    localparam int MAX_ENTRIES_RESET = 10;

    localparam int CMD_W   = 1;
    localparam int SCORE_W = 32;
    localparam int KEPT_W  = 31;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 4;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          player_tag;
        logic [IDX_W-1:0]          read_index;
    } t_req;

    typedef struct packed {
        logic                qualified;
        logic                kept;
        logic [RANK_W-1:0]   rank;
        logic [KEPT_W-1:0]   best_score;
        logic [COUNT_W-1:0]  entry_count;
        logic                read_valid;
        logic [KEPT_W-1:0]   read_score;
        logic [TAG_W-1:0]    read_tag;
    } t_result;

    typedef struct packed {
        logic             wr;
        logic [CFG_W-1:0] value;
    } t_cfg_wr;

endpackage

### rtl/tkst_if.sv
// Interfaces: request, result and configuration channels of the score table.
`timescale 1ns / 1ps
interface tkst_in_if;
    import tkst_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          player_tag;
    logic [IDX_W-1:0]          read_index;
    modport source (output valid, cmd, score, player_tag, read_index, input ready);
    modport sink   (input valid, cmd, score, player_tag, read_index, output ready);
endinterface

interface tkst_out_if;
    import tkst_pkg::*;
    logic                valid;
    logic                ready;
    logic                qualified;
    logic                kept;
    logic [RANK_W-1:0]   rank;
    logic [KEPT_W-1:0]   best_score;
    logic [COUNT_W-1:0]  entry_count;
    logic                read_valid;
    logic [KEPT_W-1:0]   read_score;
    logic [TAG_W-1:0]    read_tag;
    modport source (output valid, qualified, kept, rank, best_score, entry_count,
                     read_valid, read_score, read_tag, input ready);
    modport sink   (input valid, qualified, kept, rank, best_score, entry_count,
                     read_valid, read_score, read_tag, output ready);
endinterface

interface tkst_cfg_if;
    import tkst_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_entries;
    modport source (output valid, max_entries, input ready);
    modport sink   (input valid, max_entries, output ready);
endinterface

### rtl/tkst_table.sv
// Score table: lane registers with parallel compare, insert shift, read select and limit.
`timescale 1ns / 1ps
module tkst_table #(
    parameter int CAPACITY = tkst_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = tkst_pkg::TAG_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tkst_pkg::t_req    i_req,
    input  tkst_pkg::t_cfg_wr i_cfg,
    output tkst_pkg::t_result o_result
);
    import tkst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RESET_LIMIT = (MAX_ENTRIES_RESET > CAPACITY) ? CAPACITY : MAX_ENTRIES_RESET;

    logic [KEPT_W-1:0]   r_score [CAPACITY];
    logic [TAG_BITS-1:0] r_tag   [CAPACITY];
    logic [KEPT_W-1:0]   n_score [CAPACITY];
    logic [TAG_BITS-1:0] n_tag   [CAPACITY];
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_limit, n_limit;

    logic [CAPACITY-1:0] ge, le, at, in_lim, rsel;
    logic [KEPT_W-1:0]   s;
    logic [TAG_BITS-1:0] new_tag;
    logic                ins, kept, sorted_ok;
    logic [POS_W-1:0]    pos;
    logic [LIM_W-1:0]    cfg_w;
    logic [KEPT_W-1:0]   rd_score;
    logic [TAG_BITS-1:0] rd_tag;

    assign s       = i_req.score[KEPT_W-1:0];
    assign new_tag = TAG_BITS'(i_req.player_tag);
    assign ins     = i_accept && (i_req.cmd == CMD_INSERT) && !i_req.score[SCORE_W-1];

    // lane compares; valid entries are sorted so ge is a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i]     = (CNT_W'(i) < r_count) && (r_score[i] >= s);
            le[i]     = (CNT_W'(i) < r_count) && (r_score[i] <= s);
            in_lim[i] = CNT_W'(i) < r_limit;
            rsel[i]   = (i < (1 << IDX_W)) && (i_req.read_index == IDX_W'(i))
                        && (CNT_W'(i) < r_count);
        end
        at[0] = !ge[0];
        for (int i = 1; i < CAPACITY; i++) begin
            at[i] = !ge[i] && ge[i-1];
        end
    end

    always_comb begin
        pos      = '0;
        rd_score = '0;
        rd_tag   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (at[i]) begin
                pos = pos | POS_W'(i);
            end
            if (rsel[i]) begin
                rd_score = rd_score | r_score[i];
                rd_tag   = rd_tag | r_tag[i];
            end
        end
    end

    assign kept = |(at & in_lim);

    // new limit from a config request
    always_comb begin
        cfg_w = LIM_W'(i_cfg.value);
        if (cfg_w == '0) begin
            n_limit = CNT_W'(1);
        end else if (cfg_w > LIM_W'(CAPACITY)) begin
            n_limit = CNT_W'(CAPACITY);
        end else begin
            n_limit = CNT_W'(cfg_w);
        end
    end

    always_comb begin
        n_score = r_score;
        n_tag   = r_tag;
        n_count = r_count;
        if (i_cfg.wr) begin
            n_count = (r_count > n_limit) ? n_limit : r_count;
        end else if (ins && kept) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (at[i]) begin
                    n_score[i] = s;
                    n_tag[i]   = new_tag;
                end else if (!ge[i] && i > 0) begin
                    n_score[i] = r_score[i-1];
                    n_tag[i]   = r_tag[i-1];
                end
            end
            if (r_count < r_limit) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_result = '0;
        o_result.entry_count = COUNT_W'(n_count);
        o_result.best_score  = (n_count != '0) ? n_score[0] : '0;
        if (i_req.cmd == CMD_INSERT) begin
            if (!i_req.score[SCORE_W-1]) begin
                o_result.qualified = (s != '0) && ((r_count < r_limit) || (|le));
                o_result.kept      = kept;
                o_result.rank      = kept ? RANK_W'(pos) : '0;
            end
        end else begin
            o_result.read_valid = |rsel;
            o_result.read_score = rd_score;
            o_result.read_tag   = TAG_W'(rd_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= CNT_W'(RESET_LIMIT);
        end else begin
            r_count <= n_count;
            if (i_cfg.wr) begin
                r_limit <= n_limit;
            end
        end
    end

    always_comb begin
        sorted_ok = 1'b1;
        for (int i = 0; i + 1 < CAPACITY; i++) begin
            if ((CNT_W'(i + 1) < r_count) && (r_score[i] < r_score[i+1])) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_limit)
        else $error("entry count above limit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.wr |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sorted_ok)
        else $error("valid entries out of order");

    a_no_insert_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg.wr && !ins) |=> r_count == $past(r_count))
        else $error("entry count changed without an insert");

endmodule

### rtl/top_k_score_table.sv
// Top level: top-k score table with request/result handshake and output register.
//
//  channel  | dir | fields                                                  | transfer
//  i_req    | in  | cmd, score, player_tag, read_index                     | valid && ready
//  o_res    | out | qualified, kept, rank, best_score, entry_count,        | valid && ready
//           |     | read_valid, read_score, read_tag                        |
//  i_cfg    | in  | max_entries                                             | valid && ready
//
//  One request per cycle unless o_res stalls; its result is registered on the next cycle.
//  Insert compare, shift and read select are combinational over the lane registers.
//  Synchronous active-low reset clears the entry count and sets the limit to 10; no sweep.
//  A request is taken while the output register is empty or being drained.
//  i_cfg is always ready.
`timescale 1ns / 1ps
module top_k_score_table #(
    parameter int CAPACITY = tkst_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = tkst_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkst_in_if.sink     i_req,
    tkst_out_if.source  o_res,
    tkst_cfg_if.sink    i_cfg
);
    import tkst_pkg::*;

    t_req    req;
    t_result result;
    t_result r_out;
    t_cfg_wr cfg;
    logic    r_out_valid;
    logic    req_accept;

    assign i_cfg.ready = 1'b1;
    assign cfg.wr      = i_cfg.valid;
    assign cfg.value   = i_cfg.max_entries;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    assign req.cmd        = i_req.cmd;
    assign req.score      = i_req.score;
    assign req.player_tag = i_req.player_tag;
    assign req.read_index = i_req.read_index;

    tkst_table #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (req_accept),
        .i_req    (req),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_out <= result;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.qualified   = r_out.qualified;
    assign o_res.kept        = r_out.kept;
    assign o_res.rank        = r_out.rank;
    assign o_res.best_score  = r_out.best_score;
    assign o_res.entry_count = r_out.entry_count;
    assign o_res.read_valid  = r_out.read_valid;
    assign o_res.read_score  = r_out.read_score;
    assign o_res.read_tag    = r_out.read_tag;

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> r_out_valid)
        else $error("request taken but no result registered");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(req_accept))
        else $error("result appeared without a request");

endmodule

### tb/top_k_score_table_test.sv
// Testbench for top_k_score_table: directed and random requests against a sorted-table predictor.
`timescale 1ns / 1ps
module top_k_score_table_test;
    import tkst_pkg::*;

    logic clk;
    logic rst_n;

    tkst_in_if  req_if ();
    tkst_out_if res_if ();
    tkst_cfg_if cfg_if ();

    top_k_score_table u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [KEPT_W-1:0] score_tbl [CAPACITY_DEF];
    logic [TAG_W-1:0]  tag_tbl [CAPACITY_DEF];
    int unsigned       entry_cnt;
    logic [CFG_W-1:0]  max_entries_reg;

    t_result pending_results [$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          stall_go;
    int unsigned stall_left;

    int unsigned err_cnt;
    int unsigned insert_cnt;
    int unsigned read_cnt;
    int unsigned limit_wr_cnt;
    int unsigned checked_cnt;

    always #10 clk = ~clk;

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned table_limit();
        int unsigned m;
        m = max_entries_reg;
        if (m < 1) m = 1;
        if (m > CAPACITY_DEF) m = CAPACITY_DEF;
        return m;
    endfunction

    function automatic void apply_limit(logic [CFG_W-1:0] v);
        max_entries_reg = v;
        if (entry_cnt > table_limit()) entry_cnt = table_limit();
    endfunction

    function automatic t_result table_step(t_req r);
        t_result     res;
        int unsigned lim;
        int unsigned n;
        int unsigned pos;
        int unsigned last;
        int unsigned i;
        logic [KEPT_W-1:0] s;
        res = '0;
        lim = table_limit();
        n = entry_cnt;
        if (n > lim) n = lim;
        if (r.cmd == CMD_INSERT) begin
            if (!r.score[SCORE_W-1]) begin
                s = r.score[KEPT_W-1:0];
                if (s != 0 && (n < lim || (n > 0 && s >= score_tbl[n-1])))
                    res.qualified = 1'b1;
                pos = 0;
                while (pos < n && score_tbl[pos] >= s) pos++;
                if (pos < lim) begin
                    last = (n < lim) ? n : lim - 1;
                    for (i = last; i > pos; i--) begin
                        score_tbl[i] = score_tbl[i-1];
                        tag_tbl[i]   = tag_tbl[i-1];
                    end
                    score_tbl[pos] = s;
                    tag_tbl[pos]   = r.player_tag;
                    if (n < lim) n++;
                    res.kept = 1'b1;
                    res.rank = pos[RANK_W-1:0];
                end
            end
            entry_cnt = n;
        end else begin
            entry_cnt = n;
            if (r.read_index < n) begin
                res.read_valid = 1'b1;
                res.read_score = score_tbl[r.read_index];
                res.read_tag   = tag_tbl[r.read_index];
            end
        end
        res.best_score  = (entry_cnt > 0) ? score_tbl[0] : '0;
        res.entry_count = entry_cnt[COUNT_W-1:0];
        return res;
    endfunction

    function automatic t_req make_req(logic [CMD_W-1:0] cmd, logic signed [SCORE_W-1:0] score,
                                      logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
        t_req r;
        r.cmd        = cmd;
        r.score      = score;
        r.player_tag = tag;
        r.read_index = idx;
        return r;
    endfunction

    // mostly inserts; small scores and copies of the lowest kept score force ties
    function automatic t_req random_req();
        t_req        r;
        int unsigned sel;
        int unsigned n;
        r.cmd        = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_INSERT;
        r.player_tag = TAG_W'($urandom_range(0, 65535));
        r.read_index = IDX_W'($urandom_range(0, 15));
        sel = $urandom_range(0, 99);
        n = (entry_cnt < table_limit()) ? entry_cnt : table_limit();
        if (sel < 40)
            r.score = $urandom_range(0, 15);
        else if (sel < 60)
            r.score = {1'b0, 31'($urandom)};
        else if (sel < 70)
            r.score = {1'b1, 31'($urandom)};
        else if (sel < 78)
            r.score = 0;
        else if (sel < 88)
            r.score = 32'h7FFF_FFFF - $urandom_range(0, 3);
        else if (n > 0)
            r.score = {1'b0, score_tbl[n-1]};
        else
            r.score = $urandom_range(0, 3);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic send_req(t_req r);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= r.cmd;
        req_if.score      <= r.score;
        req_if.player_tag <= r.player_tag;
        req_if.read_index <= r.read_index;
        do @(posedge clk); while (!req_if.ready);
        pending_results.insert(pending_results.size(), table_step(r));
        if (r.cmd == CMD_INSERT) insert_cnt++;
        else read_cnt++;
    endtask

    task automatic write_max_entries(logic [CFG_W-1:0] v);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.max_entries <= v;
        do @(posedge clk); while (!cfg_if.ready);
        apply_limit(v);
        limit_wr_cnt++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        if (stall_go) begin
            stall_left = 60;
            stall_go   = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", 0, 0);
            end else begin
                want = pending_results.pop_front();
                checked_cnt++;
                if (res_if.qualified !== want.qualified)
                    report_mismatch("qualified", res_if.qualified, want.qualified);
                if (res_if.kept !== want.kept)
                    report_mismatch("kept", res_if.kept, want.kept);
                if (res_if.rank !== want.rank)
                    report_mismatch("rank", res_if.rank, want.rank);
                if (res_if.best_score !== want.best_score)
                    report_mismatch("best_score", res_if.best_score, want.best_score);
                if (res_if.entry_count !== want.entry_count)
                    report_mismatch("entry_count", res_if.entry_count, want.entry_count);
                if (res_if.read_valid !== want.read_valid)
                    report_mismatch("read_valid", res_if.read_valid, want.read_valid);
                if (res_if.read_score !== want.read_score)
                    report_mismatch("read_score", res_if.read_score, want.read_score);
                if (res_if.read_tag !== want.read_tag)
                    report_mismatch("read_tag", res_if.read_tag, want.read_tag);
            end
        end
    end

    task automatic test_empty_table();
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd0));
        send_req(make_req(CMD_READ, -1, 16'hFFFF, 4'd15));
        send_req(make_req(CMD_INSERT, -1, 16'h1234, 4'd0));
        send_req(make_req(CMD_INSERT, 32'sh8000_0000, 16'hFFFF, 4'd15));
    endtask

    task automatic test_insert_order();
        send_req(make_req(CMD_INSERT, 0, 16'h0000, 4'd0));
        send_req(make_req(CMD_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 4'd0));
        send_req(make_req(CMD_INSERT, 5, 16'h0001, 4'd0));
        send_req(make_req(CMD_INSERT, 5, 16'h0002, 4'd0));
        send_req(make_req(CMD_INSERT, 0, 16'h0003, 4'd0));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd2));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd3));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd4));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd15));
    endtask

    task automatic test_full_table();
        send_req(make_req(CMD_INSERT, 100, 16'h0100, 4'd0));
        send_req(make_req(CMD_INSERT, 90, 16'h0090, 4'd0));
        send_req(make_req(CMD_INSERT, 80, 16'h0080, 4'd0));
        send_req(make_req(CMD_INSERT, 70, 16'h0070, 4'd0));
        send_req(make_req(CMD_INSERT, 60, 16'h0060, 4'd0));
        // full: zero cannot get in, small scores push out the zeros
        send_req(make_req(CMD_INSERT, 0, 16'h0004, 4'd0));
        send_req(make_req(CMD_INSERT, 1, 16'h0005, 4'd0));
        send_req(make_req(CMD_INSERT, 2, 16'h0006, 4'd0));
        // ties the lowest: qualifies but lands past the end
        send_req(make_req(CMD_INSERT, 1, 16'h0007, 4'd0));
        send_req(make_req(CMD_INSERT, -5, 16'h0008, 4'd0));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd9));
    endtask

    task automatic test_limit_extremes();
        write_max_entries(5'd0);
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd0));
        send_req(make_req(CMD_INSERT, 32'sh7FFF_FFFF, 16'hAAAA, 4'd0));
        send_req(make_req(CMD_INSERT, 3, 16'h5555, 4'd0));
        write_max_entries(5'd31);
        repeat (4) send_req(make_req(CMD_INSERT, $urandom_range(1, 50), 16'h00F0, 4'd0));
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd15));
        write_max_entries(5'd16);
        write_max_entries(5'd2);
        send_req(make_req(CMD_READ, 0, 16'h0000, 4'd1));
        write_max_entries(5'd10);
    endtask

    task automatic test_output_stall();
        write_max_entries(5'd16);
        stall_go = 1'b1;
        repeat (20) send_req(random_req());
    endtask

    task automatic test_random(int unsigned per_limit);
        int unsigned k;
        logic [CFG_W-1:0] v;
        for (k = 0; k < 6; k++) begin
            case (k)
                0: v = 5'd16;
                1: v = 5'd1;
                2: v = CFG_W'($urandom_range(2, 15));
                3: v = 5'd0;
                4: v = 5'd31;
                default: v = CFG_W'($urandom_range(0, 31));
            endcase
            write_max_entries(v);
            repeat (per_limit) send_req(random_req());
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_INSERT;
        req_if.score = '0;
        req_if.player_tag = '0;
        req_if.read_index = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.max_entries = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_go = 1'b0;
        stall_left = 0;
        err_cnt = 0;
        insert_cnt = 0;
        read_cnt = 0;
        limit_wr_cnt = 0;
        checked_cnt = 0;
        entry_cnt = 0;
        max_entries_reg = CFG_W'(MAX_ENTRIES_RESET);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_insert_order();
        test_full_table();
        test_limit_extremes();
        test_output_stall();

        src_idle_pct = 36;
        snk_idle_pct = 86;
        test_random(105);
        src_idle_pct = 86;
        snk_idle_pct = 36;
        test_random(105);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(105);

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("ran %0d inserts and %0d reads over %0d table limit writes",
                 insert_cnt, read_cnt, limit_wr_cnt);
        $display("%0d results checked, %0d mismatches", checked_cnt, err_cnt);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
rtl/tkst_pkg.sv
rtl/tkst_if.sv
rtl/tkst_table.sv
rtl/top_k_score_table.sv
tb/top_k_score_table_test.sv
